/* hdl/mlt_pkg.sv */
// Shared types and constants for the MAC learning table.
// No dependencies.
`default_nettype none
package mlt_pkg;
  // port field width and the width of one queued item payload
  localparam int PORT_BITS = 9;
  localparam int QW        = 48 + PORT_BITS + 4 + 32;

  typedef enum logic [2:0] {
    MODE_LEARN     = 3'd0,
    MODE_INSERT    = 3'd1,
    MODE_LOOKUP    = 3'd2,
    MODE_DEL_ADDR  = 3'd3,
    MODE_DEL_PORT  = 3'd4,
    MODE_FLUSH     = 3'd5,
    MODE_AGE       = 3'd6,
    MODE_NONE      = 3'd7
  } mode_t;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_LOCAL    = 3'd4;

  localparam logic [1:0] CFG_AGEING  = 2'd0;
  localparam logic [1:0] CFG_FWD     = 2'd1;
  localparam logic [1:0] CFG_TC      = 2'd2;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CLEAR,
    BK_SCAN,
    BK_WAIT,
    BK_EXEC,
    BK_OUT
  } bk_state_t;

  // walk kinds decided by the front end
  typedef struct packed {
    logic [2:0]  mode;
    logic        addr_ok;
    logic        learn_en;
  } cls_t;
endpackage
`default_nettype wire

/* hdl/mlt_if.sv */
// Valid/ready channel interface carrying a payload.
// Depends on nothing.
`default_nettype none
interface mlt_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/mlt_front.sv */
// Front end: accepts items, classifies them and queues them for the back end.
// Depends on mlt_pkg.
`default_nettype none
module mlt_front
  import mlt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [2:0]           in_mode,
  input  wire logic [47:0]          in_mac,
  input  wire logic [PORT_BITS-1:0] in_port,
  input  wire logic                 in_learn,
  input  wire logic                 in_local,
  input  wire logic                 in_static,
  input  wire logic                 in_incl,
  input  wire logic [31:0]          in_now,
  input  wire logic [31:0]          hold,
  output logic                      q_valid,
  input  wire logic                 q_ready,
  output cls_t                      q_cls,
  output logic [QW-1:0]             q_data
);
  // two-entry queue
  logic [1:0]              vld_r, vld_nxt;
  logic                    rd_r, wr_r;
  logic [QW+4:0]           mem_r [2];
  logic [QW+4:0]           wdata;
  cls_t                    cls;
  logic                    push, pop;

  always_comb begin
    cls.mode     = in_mode;
    cls.addr_ok  = (in_mac != 48'd0) && !in_mac[40];
    cls.learn_en = (hold != 32'd0) && in_learn;
    wdata = {cls, in_mac, in_port, in_learn, in_local, in_static, in_incl, in_now};
  end

  assign in_ready = !vld_r[wr_r];
  assign push     = in_valid && in_ready;
  assign q_valid  = vld_r[rd_r];
  assign pop      = q_valid && q_ready;
  assign q_cls    = mem_r[rd_r][QW+4:QW];
  assign q_data   = mem_r[rd_r][QW-1:0];

  always_comb begin
    vld_nxt = vld_r;
    if (push) vld_nxt[wr_r] = 1'b1;
    if (pop)  vld_nxt[rd_r] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= wdata;
    if (!rst_n) begin
      vld_r <= 2'b00;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      if (push) wr_r <= !wr_r;
      if (pop)  rd_r <= !rd_r;
    end
  end
endmodule
`default_nettype wire

/* hdl/mlt_back.sv */
// Back end: table memory, search/walk sequencer and result register.
// Depends on mlt_pkg.
`default_nettype none
module mlt_back
  import mlt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  output logic                   q_ready,
  input  wire cls_t              q_cls,
  input  wire logic [QW-1:0]     q_data,
  input  wire logic [31:0]       hold,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [2:0]             out_status,
  output logic                   out_hit,
  output logic [PORT_BITS-1:0]   out_fport,
  output logic                   out_flocal,
  output logic                   out_fstatic
);
  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int IW = 32 + PORT_BITS + 2;
  localparam logic [PORT_BITS-1:0] NO_PORT = PORT_BITS'(256);

  logic [48:0]    key_mem [TABLE_ENTRIES];
  logic [IW-1:0]  info_mem [TABLE_ENTRIES];
  logic [48:0]    key_rd_r;
  logic [IW-1:0]  info_rd_r;

  bk_state_t st_r, st_nxt;
  logic [AW:0]   idx_r, idx_nxt;
  logic [AW-1:0] rd_addr;
  logic          found_r, found_nxt, free_r, free_nxt;
  logic [AW-1:0] fidx_r, fidx_nxt, eidx_r, eidx_nxt;
  logic [IW-1:0] finfo_r, finfo_nxt;
  logic          we;
  logic [AW-1:0] waddr;
  logic [48:0]   wkey;
  logic [IW-1:0] winfo;
  logic          winfo_en;
  logic          chk_r, chk_nxt;
  logic [AW-1:0] chk_idx_r;

  logic [2:0]          ost_r, ost_nxt;
  logic                ohit_r, ohit_nxt;
  logic [PORT_BITS-1:0] oport_r, oport_nxt;
  logic                oloc_r, oloc_nxt, osta_r, osta_nxt;
  logic                ov_r, ov_nxt;

  // payload fields
  logic [47:0]          mac;
  logic [PORT_BITS-1:0] port;
  logic                 sloc, ssta, incl;
  logic [31:0]          now;
  assign mac  = q_data[QW-1 -: 48];
  assign port = q_data[QW-49 -: PORT_BITS];
  assign sloc = q_data[QW-49-PORT_BITS-1];
  assign ssta = q_data[QW-49-PORT_BITS-2];
  assign incl = q_data[QW-49-PORT_BITS-3];
  assign now  = q_data[QW-49-PORT_BITS-4 -: 32];

  function automatic logic is_exp(logic [IW-1:0] inf, logic [31:0] t, logic [31:0] h);
    logic [31:0] d;
    d = t - (inf[31:0] + h);
    return !inf[IW-1] && !d[31];
  endfunction

  assign rd_addr = idx_r[AW-1:0];

  always_ff @(posedge clk) begin
    key_rd_r  <= key_mem[rd_addr];
    info_rd_r <= info_mem[rd_addr];
    if (we) key_mem[waddr] <= wkey;
    if (we && winfo_en) info_mem[waddr] <= winfo;
  end

  always_comb begin
    logic          hitk, mine;
    st_nxt = st_r; idx_nxt = idx_r; found_nxt = found_r; free_nxt = free_r;
    fidx_nxt = fidx_r; eidx_nxt = eidx_r; finfo_nxt = finfo_r;
    we = 1'b0; waddr = chk_idx_r; wkey = 49'd0; winfo = '0; winfo_en = 1'b0;
    chk_nxt = 1'b0; q_ready = 1'b0;
    ost_nxt = ost_r; ohit_nxt = ohit_r; oport_nxt = oport_r;
    oloc_nxt = oloc_r; osta_nxt = osta_r; ov_nxt = ov_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    hitk = key_rd_r == {1'b1, mac};
    mine = 1'b0;
    case (st_r)
      BK_CLEAR: begin
        we = 1'b1; waddr = idx_r[AW-1:0]; winfo_en = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == (AW+1)'(TABLE_ENTRIES - 1)) st_nxt = BK_IDLE;
      end
      BK_IDLE: begin
        if (q_valid && !ov_r) begin
          idx_nxt = '0; found_nxt = 1'b0; free_nxt = 1'b0;
          st_nxt = BK_SCAN;
        end
      end
      BK_SCAN: begin
        // read address idx_r issued; data for chk_idx_r visible now
        if (chk_r) begin
          case (q_cls.mode)
            MODE_DEL_PORT: mine = key_rd_r[48] && info_rd_r[IW-3 -: PORT_BITS] == port
                                   && (!info_rd_r[IW-1] || incl);
            MODE_FLUSH:    mine = key_rd_r[48] && !info_rd_r[IW-1];
            MODE_AGE:      mine = key_rd_r[48] && is_exp(info_rd_r, now, hold);
            default:       mine = 1'b0;
          endcase
          if (mine) begin
            we = 1'b1; waddr = chk_idx_r;
          end
          if (hitk && !found_r) begin
            found_nxt = 1'b1; fidx_nxt = chk_idx_r; finfo_nxt = info_rd_r;
          end
          if (!key_rd_r[48] && !free_r) begin
            free_nxt = 1'b1; eidx_nxt = chk_idx_r;
          end
        end
        if (idx_r == (AW+1)'(TABLE_ENTRIES)) st_nxt = BK_WAIT;
        else begin
          idx_nxt = idx_r + 1'b1; chk_nxt = 1'b1;
        end
      end
      BK_WAIT: st_nxt = BK_EXEC;
      BK_EXEC: begin
        ost_nxt = ST_OK; ohit_nxt = 1'b0; oport_nxt = NO_PORT;
        oloc_nxt = 1'b0; osta_nxt = 1'b0;
        case (q_cls.mode)
          MODE_LEARN, MODE_INSERT: begin
            if (q_cls.mode == MODE_LEARN && !q_cls.learn_en) begin
              ost_nxt = ST_OK;
            end else if (found_r && finfo_r[IW-2]) begin
              ost_nxt = (q_cls.mode == MODE_LEARN) ? ST_LOCAL : ST_OK;
            end else if (found_r && q_cls.mode == MODE_LEARN) begin
              we = 1'b1; waddr = fidx_r; wkey = {1'b1, mac}; winfo_en = 1'b1;
              winfo = {finfo_r[IW-1], 1'b0, port, now};
            end else if (!q_cls.addr_ok) begin
              ost_nxt = ST_INVALID;
            end else if (!found_r && !free_r) begin
              ost_nxt = ST_FULL;
            end else begin
              we = 1'b1; waddr = found_r ? fidx_r : eidx_r; wkey = {1'b1, mac};
              winfo_en = 1'b1;
              winfo = (q_cls.mode == MODE_LEARN) ? {2'b00, port, now}
                                                 : {ssta, sloc, port, now};
            end
          end
          MODE_LOOKUP: begin
            if (!found_r || is_exp(finfo_r, now, hold)) ost_nxt = ST_NOTFOUND;
            else begin
              ohit_nxt = 1'b1; oport_nxt = finfo_r[IW-3 -: PORT_BITS];
              oloc_nxt = finfo_r[IW-2]; osta_nxt = finfo_r[IW-1];
            end
          end
          MODE_DEL_ADDR: begin
            if (!found_r) ost_nxt = ST_NOTFOUND;
            else begin
              we = 1'b1; waddr = fidx_r;
            end
          end
          default: ost_nxt = ST_OK;
        endcase
        ov_nxt = 1'b1; q_ready = 1'b1; st_nxt = BK_IDLE;
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    chk_idx_r <= rd_addr;
    fidx_r <= fidx_nxt; eidx_r <= eidx_nxt; finfo_r <= finfo_nxt;
    ost_r <= ost_nxt; ohit_r <= ohit_nxt; oport_r <= oport_nxt;
    oloc_r <= oloc_nxt; osta_r <= osta_nxt;
    if (!rst_n) begin
      st_r <= BK_CLEAR; idx_r <= '0; found_r <= 1'b0; free_r <= 1'b0;
      chk_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; idx_r <= idx_nxt; found_r <= found_nxt; free_r <= free_nxt;
      chk_r <= chk_nxt; ov_r <= ov_nxt;
    end
  end

  assign out_valid = ov_r; assign out_status = ost_r; assign out_hit = ohit_r;
  assign out_fport = oport_r; assign out_flocal = oloc_r; assign out_fstatic = osta_r;

  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_status == ST_OK) else $error("hit with bad status");
  a_nohit_port: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_fport == NO_PORT) else $error("miss carries port");
  a_pop_exec: assert property (@(posedge clk) disable iff (!rst_n)
    q_ready |-> st_r == BK_EXEC) else $error("queue popped outside exec");
  a_result_set: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == BK_EXEC |=> out_valid) else $error("result not raised");
endmodule
`default_nettype wire

/* hdl/mac_learning_table_with_ageing_top.sv */
// Top level of the MAC learning table: config registers, front and back ends.
// Depends on mlt_pkg, mlt_if, mlt_front, mlt_back.
// Each item walks the whole key memory through its single read port, and the next item
// is not started until that item's result has been taken; a held result keeps the next
// item waiting in the two-entry queue.
// After reset a clearing pass over every table entry runs before any item is started.
`default_nettype none
module mac_learning_table_with_ageing_top
  import mlt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 1024
) (
  input  wire logic clk,
  input  wire logic rst_n,
  mlt_if.sink       in_ch,
  mlt_if.source     out_ch,
  mlt_if.sink       cfg_ch
);
  logic [31:0] ageing_r, fwd_r;
  logic        tc_r;
  logic [31:0] hold;
  logic        qv, qr;
  cls_t        qc;
  logic [QW-1:0] qd;
  logic [2:0]  ost;
  logic        ohit, floc, fsta;
  logic [PORT_BITS-1:0] fp;

  // in_ch.data: {now[31:0], incl, static, local, learn, port[8:0], mac[47:0], mode[2:0]}
  // cfg_ch.data: {value[31:0], index[1:0]}
  // out_ch.data: {fstatic, flocal, fport[8:0], hit, status[2:0]}
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ageing_r <= 32'd30000; fwd_r <= 32'd1500; tc_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.data[1:0])
        CFG_AGEING: ageing_r <= cfg_ch.data[33:2];
        CFG_FWD:    fwd_r    <= cfg_ch.data[33:2];
        CFG_TC:     tc_r     <= cfg_ch.data[2];
        default:    ;
      endcase
    end
  end
  assign hold = tc_r ? fwd_r : ageing_r;

  mlt_front u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_mode(in_ch.data[2:0]), .in_mac(in_ch.data[50:3]), .in_port(in_ch.data[59:51]),
    .in_learn(in_ch.data[60]), .in_local(in_ch.data[61]), .in_static(in_ch.data[62]),
    .in_incl(in_ch.data[63]), .in_now(in_ch.data[95:64]), .hold,
    .q_valid(qv), .q_ready(qr), .q_cls(qc), .q_data(qd)
  );

  mlt_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk, .rst_n, .q_valid(qv), .q_ready(qr), .q_cls(qc), .q_data(qd), .hold,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_status(ost), .out_hit(ohit), .out_fport(fp),
    .out_flocal(floc), .out_fstatic(fsta)
  );
  assign out_ch.data = {fsta, floc, fp, ohit, ost};
endmodule
`default_nettype wire

/* test/mlt_test_if.sv */
// Channel interface instances used by the testbench are mlt_if from the RTL.
// This file holds the payload layouts of the three channels; depends on mlt_pkg.
`timescale 1ns / 1ps
package mlt_test_pkg;
  import mlt_pkg::*;

  typedef struct packed {
    logic [31:0] now_time;
    logic        include_static;
    logic        set_static;
    logic        set_local;
    logic        port_learning;
    logic [8:0]  port;
    logic [47:0] mac;
    mode_t       mode;
  } op_item_t;

  typedef struct packed {
    logic       found_static;
    logic       found_local;
    logic [8:0] found_port;
    logic       hit;
    logic [2:0] status;
  } op_result_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  idx;
  } cfg_item_t;
endpackage

/* test/mac_learning_table_with_ageing_top_test.sv */
// Self-checking testbench for the MAC learning table: a shadow table predicts
// every result, compared field by field as results leave. Depends on mlt_pkg,
// mlt_if, mlt_test_pkg and the top level.
`timescale 1ns / 1ps
module mac_learning_table_with_ageing_top_test;
  import mlt_pkg::*;
  import mlt_test_pkg::*;

  localparam int SLOTS   = 1024;
  localparam int NO_PORT = 256;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mlt_if #(.W($bits(op_item_t)))   in_ch ();
  mlt_if #(.W($bits(op_result_t))) out_ch ();
  mlt_if #(.W($bits(cfg_item_t)))  cfg_ch ();

  mac_learning_table_with_ageing_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow table
  logic        sh_valid [SLOTS];
  logic [47:0] sh_mac [SLOTS];
  logic [31:0] sh_time [SLOTS];
  logic [8:0]  sh_port [SLOTS];
  logic        sh_local [SLOTS];
  logic        sh_static [SLOTS];
  logic [31:0] age_ticks, fwd_ticks;
  logic        tc_on;

  op_result_t pending_results[$];
  int  errors = 0;
  int  gap_pct = 0, stall_pct = 0;
  logic [31:0] clock_tick = 32'd100;
  logic [47:0] mac_pool [16];

  function automatic logic [31:0] hold_ticks();
    return tc_on ? fwd_ticks : age_ticks;
  endfunction

  function automatic bit is_stale(int s, logic [31:0] now);
    logic [31:0] limit;
    if (sh_static[s]) return 1'b0;
    limit = sh_time[s] + hold_ticks();
    return (now - limit) < 32'h8000_0000;
  endfunction

  function automatic int slot_of(logic [47:0] mac);
    for (int i = 0; i < SLOTS; i++)
      if (sh_valid[i] && sh_mac[i] == mac) return i;
    return -1;
  endfunction

  function automatic logic [2:0] table_add(op_item_t it, logic loc, logic stc);
    int s;
    if (it.mac == 48'd0 || it.mac[40]) return ST_INVALID;
    s = slot_of(it.mac);
    if (s >= 0 && sh_local[s]) return ST_OK;
    if (s < 0)
      for (int i = 0; i < SLOTS; i++)
        if (!sh_valid[i]) begin
          s = i;
          break;
        end
    if (s < 0) return ST_FULL;
    sh_valid[s] = 1'b1;
    sh_mac[s] = it.mac;
    sh_time[s] = it.now_time;
    sh_port[s] = it.port;
    sh_local[s] = loc;
    sh_static[s] = stc;
    return ST_OK;
  endfunction

  function automatic op_result_t table_apply(op_item_t it);
    op_result_t r;
    int s;
    r = '{status: ST_OK, hit: 1'b0, found_port: 9'(NO_PORT), found_local: 1'b0,
          found_static: 1'b0};
    case (it.mode)
      MODE_LEARN: begin
        if (hold_ticks() != 0 && it.port_learning) begin
          s = slot_of(it.mac);
          if (s >= 0) begin
            if (sh_local[s]) r.status = ST_LOCAL;
            else begin
              sh_time[s] = it.now_time;
              sh_port[s] = it.port;
            end
          end else r.status = table_add(it, 1'b0, 1'b0);
        end
      end
      MODE_INSERT: r.status = table_add(it, it.set_local, it.set_static);
      MODE_LOOKUP: begin
        s = slot_of(it.mac);
        if (s < 0 || is_stale(s, it.now_time)) r.status = ST_NOTFOUND;
        else begin
          r.hit = 1'b1;
          r.found_port = sh_port[s];
          r.found_local = sh_local[s];
          r.found_static = sh_static[s];
        end
      end
      MODE_DEL_ADDR: begin
        s = slot_of(it.mac);
        if (s < 0) r.status = ST_NOTFOUND;
        else sh_valid[s] = 1'b0;
      end
      MODE_DEL_PORT:
        for (int i = 0; i < SLOTS; i++)
          if (sh_valid[i] && sh_port[i] == it.port && (!sh_static[i] || it.include_static))
            sh_valid[i] = 1'b0;
      MODE_FLUSH:
        for (int i = 0; i < SLOTS; i++)
          if (!sh_static[i]) sh_valid[i] = 1'b0;
      MODE_AGE:
        for (int i = 0; i < SLOTS; i++)
          if (sh_valid[i] && is_stale(i, it.now_time)) sh_valid[i] = 1'b0;
      default: ;
    endcase
    return r;
  endfunction

  // result side: random back-pressure and checking
  always @(posedge clk) begin
    op_result_t got, want;
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.hit !== want.hit ||
            got.found_port !== want.found_port || got.found_local !== want.found_local ||
            got.found_static !== want.found_static) begin
          $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
          errors++;
        end
      end
    end
  end

  task automatic send_op(op_item_t it);
    int g;
    g = 0;
    if ($urandom_range(99) < gap_pct) g = $urandom_range(6, 1);
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(table_apply(it));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    cfg_item_t c;
    c.idx = idx;
    c.value = value;
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= c;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_AGEING: age_ticks = value;
      CFG_FWD:    fwd_ticks = value;
      CFG_TC:     tc_on = value[0];
      default:    ;
    endcase
    @(posedge clk);
  endtask

  function automatic op_item_t make_op(mode_t m, logic [47:0] mac, logic [8:0] port,
                                       logic [31:0] now);
    op_item_t it;
    it = '{mode: m, mac: mac, port: port, port_learning: 1'b1, set_local: 1'b0,
           set_static: 1'b0, include_static: 1'b0, now_time: now};
    return it;
  endfunction

  task automatic test_directed();
    op_item_t it;
    gap_pct = 0;
    stall_pct = 0;
    send_op(make_op(MODE_INSERT, 48'd0, 9'd1, 32'd0));                // zero address
    send_op(make_op(MODE_LEARN, 48'h0100_0000_0000, 9'd1, 32'd0));    // multicast
    send_op(make_op(MODE_INSERT, 48'hFFFF_FFFF_FFFF, 9'd1, 32'd0));
    send_op(make_op(MODE_INSERT, 48'hFEFF_FFFF_FFFF, 9'd511, 32'hFFFF_FFFF));
    it = make_op(MODE_LEARN, 48'h0000_0000_0002, 9'd3, 32'd10);
    it.port_learning = 1'b0;
    send_op(it);                                                     // learning off
    send_op(make_op(MODE_LOOKUP, 48'h0000_0000_0002, 9'd0, 32'd10));
    it = make_op(MODE_INSERT, 48'h0200_0000_0001, 9'(NO_PORT), 32'd5);
    it.set_local = 1'b1;
    send_op(it);
    send_op(make_op(MODE_LEARN, 48'h0200_0000_0001, 9'd2, 32'd6));    // own address
    send_op(make_op(MODE_INSERT, 48'h0200_0000_0001, 9'd2, 32'd6));    // insert on local
    send_op(make_op(MODE_LOOKUP, 48'h0200_0000_0001, 9'd0, 32'd7));
    send_op(make_op(MODE_LOOKUP, 48'h0200_0000_0001, 9'd0, 32'd30005)); // local expired
    it = make_op(MODE_INSERT, 48'h0200_0000_0003, 9'd4, 32'd0);
    it.set_static = 1'b1;
    send_op(it);
    send_op(make_op(MODE_LEARN, 48'h0200_0000_0003, 9'd5, 32'd1));     // static refresh
    send_op(make_op(MODE_LOOKUP, 48'h0200_0000_0003, 9'd0, 32'h9000_0000));
    send_op(make_op(MODE_LEARN, 48'h0200_0000_0004, 9'd5, 32'hFFFF_FFF0)); // wrap
    send_op(make_op(MODE_LOOKUP, 48'h0200_0000_0004, 9'd0, 32'd100));
    send_op(make_op(MODE_AGE, 48'd0, 9'd0, 32'd40000));
    send_op(make_op(MODE_LOOKUP, 48'h0200_0000_0004, 9'd0, 32'd100));
    send_op(make_op(MODE_DEL_ADDR, 48'h0200_0000_0009, 9'd0, 32'd0));   // not found
    send_op(make_op(MODE_DEL_PORT, 48'd0, 9'd5, 32'd0));
    it = make_op(MODE_DEL_PORT, 48'd0, 9'd5, 32'd0);
    it.include_static = 1'b1;
    send_op(it);
    send_op(make_op(MODE_LEARN, 48'h0200_0000_0005, 9'd6, 32'd0));
    send_op(make_op(MODE_FLUSH, 48'd0, 9'd0, 32'd0));
    send_op(make_op(MODE_NONE, 48'hFFFF_FFFF_FFFF, 9'h1FF, 32'hFFFF_FFFF));
    send_op(make_op(MODE_LOOKUP, 48'hFEFF_FFFF_FFFF, 9'd0, 32'd0));
    drain();
  endtask

  function automatic op_item_t random_op();
    op_item_t it;
    int r;
    r = $urandom_range(99);
    it.mode = r < 30 ? MODE_LEARN : r < 45 ? MODE_INSERT : r < 75 ? MODE_LOOKUP :
              r < 83 ? MODE_DEL_ADDR : r < 89 ? MODE_DEL_PORT : r < 92 ? MODE_FLUSH :
              r < 98 ? MODE_AGE : MODE_NONE;
    it.mac = $urandom_range(9) == 0 ? {16'($urandom), 32'($urandom)}
                                     : mac_pool[$urandom_range(15)];
    r = $urandom_range(9);
    it.port = r < 6 ? 9'($urandom_range(3)) : r < 8 ? 9'(NO_PORT) : 9'($urandom);
    it.port_learning = $urandom_range(9) != 0;
    it.set_local = $urandom_range(4) == 0;
    it.set_static = $urandom_range(3) == 0;
    it.include_static = 1'($urandom_range(1));
    clock_tick += $urandom_range(12);
    it.now_time = $urandom_range(19) == 0 ? 32'($urandom) : clock_tick;
    return it;
  endfunction

  task automatic test_random(int n);
    int per;
    per = n / 4;
    for (int p = 0; p < 4; p++) begin
      gap_pct   = (p == 1 || p == 3) ? (p == 1 ? 58 : 21) : 0;
      stall_pct = (p == 2 || p == 3) ? (p == 2 ? 58 : 21) : 0;
      repeat (per) send_op(random_op());
    end
    drain();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    for (int i = 0; i < SLOTS; i++) begin
      sh_valid[i] = 1'b0; sh_mac[i] = '0; sh_time[i] = '0;
      sh_port[i] = '0; sh_local[i] = 1'b0; sh_static[i] = 1'b0;
    end
    age_ticks = 32'd30000;
    fwd_ticks = 32'd1500;
    tc_on = 1'b0;
    for (int i = 0; i < 16; i++)
      mac_pool[i] = {16'($urandom), 32'($urandom)} & ~(i < 13 ? 48'h0100_0000_0000 : 48'd0);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(160);
    // short hold times so entries expire in the random stream
    write_reg(CFG_AGEING, 32'd40);
    write_reg(CFG_FWD, 32'd7);
    test_random(140);
    write_reg(CFG_TC, 1'b1);
    test_random(120);
    write_reg(CFG_FWD, 32'd0);          // learning off during topology change
    test_random(60);
    write_reg(CFG_FWD, 32'hFFFF_FFFF);
    test_random(60);
    write_reg(CFG_TC, 1'b0);
    write_reg(CFG_AGEING, 32'd0);
    test_random(60);
    write_reg(CFG_AGEING, 32'hFFFF_FFFF);
    test_random(80);

    repeat (1100) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #30ms;
    $display("FAIL");
    $finish;
  end
endmodule
